// ===== hw/rtl/hsv_pkg.sv =====
// ----------------------------------------------------------------------------
// hsv_pkg
// Shared widths, constants and word types of the RGB to HSV converter.
// ----------------------------------------------------------------------------
package hsv_pkg;

  localparam int CH_W        = 8;
  localparam int NUM_W       = 11;    // sextant numerator, up to 6 * 255
  localparam int QUO_W       = 15;    // quotient bits, one divider stage each
  localparam int DVD_W       = 23;    // dividend, up to 1530 * 3840
  localparam int HUE_W       = 15;
  localparam int SAT_W       = 13;
  localparam int SAT_SHIFT   = 12;    // Q0.12
  localparam int SEC_W       = 12;
  localparam logic [SEC_W-1:0] HUE_SECTOR_Q6 = 12'd3840;  // 60 degrees * 64

  // word entering the divider pipeline
  typedef struct packed {
    logic [DVD_W-1:0] hue_dvd;
    logic [CH_W-1:0]  hue_dvs;
    logic [DVD_W-1:0] sat_dvd;
    logic [CH_W-1:0]  sat_dvs;
    logic [CH_W-1:0]  value;
    logic             grey;
    logic             black;
  } div_word_t;

  // word held in each divider stage
  typedef struct packed {
    logic [DVD_W-1:0] hue_rem;
    logic [CH_W-1:0]  hue_dvs;
    logic [QUO_W-1:0] hue_quo;
    logic [DVD_W-1:0] sat_rem;
    logic [CH_W-1:0]  sat_dvs;
    logic [QUO_W-1:0] sat_quo;
    logic [CH_W-1:0]  value;
    logic             grey;
    logic             black;
  } div_stage_t;

endpackage

// ===== hw/rtl/hsv_divpipe.sv =====
// ----------------------------------------------------------------------------
// hsv_divpipe
// Two restoring dividers side by side, one quotient bit per register stage,
// with a valid bit per stage and a ready chain so bubbles close up.
// ----------------------------------------------------------------------------
module hsv_divpipe (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  hsv_pkg::div_word_t in_word,
  output logic               out_valid,
  input  logic               out_ready,
  output hsv_pkg::div_stage_t out_word
);

  localparam int Depth = hsv_pkg::QUO_W;

  hsv_pkg::div_stage_t st [Depth];
  logic [Depth-1:0]    v;
  logic [Depth:0]      rdy;

  assign rdy[Depth] = out_ready;

  for (genvar i = 0; i < Depth; i++) begin : g_stage
    localparam int Sh = Depth - 1 - i;

    hsv_pkg::div_stage_t prev;
    hsv_pkg::div_stage_t nxt;
    logic                vin;
    logic [hsv_pkg::DVD_W-1:0] hue_trial;
    logic [hsv_pkg::DVD_W-1:0] sat_trial;

    if (i == 0) begin : g_first
      always_comb begin
        prev.hue_rem = in_word.hue_dvd;
        prev.hue_dvs = in_word.hue_dvs;
        prev.hue_quo = '0;
        prev.sat_rem = in_word.sat_dvd;
        prev.sat_dvs = in_word.sat_dvs;
        prev.sat_quo = '0;
        prev.value   = in_word.value;
        prev.grey    = in_word.grey;
        prev.black   = in_word.black;
      end
      assign vin = in_valid;
    end else begin : g_rest
      assign prev = st[i-1];
      assign vin  = v[i-1];
    end

    assign hue_trial = hsv_pkg::DVD_W'(prev.hue_dvs) << Sh;
    assign sat_trial = hsv_pkg::DVD_W'(prev.sat_dvs) << Sh;

    always_comb begin
      nxt = prev;
      if (prev.hue_rem >= hue_trial) begin
        nxt.hue_rem     = prev.hue_rem - hue_trial;
        nxt.hue_quo[Sh] = 1'b1;
      end
      if (prev.sat_rem >= sat_trial) begin
        nxt.sat_rem     = prev.sat_rem - sat_trial;
        nxt.sat_quo[Sh] = 1'b1;
      end
    end

    assign rdy[i] = !v[i] || rdy[i+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i] <= 1'b0;
      end else if (rdy[i]) begin
        v[i] <= vin;
      end
      if (rdy[i]) begin
        st[i] <= nxt;
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v[Depth-1];
  assign out_word  = st[Depth-1];

endmodule

// ===== hw/rtl/rgb_to_hsv_converter.sv =====
// An accepted word passes stages A, B and C, the divider stages and the output register.
// Throughput: one word per cycle while the output is not stalled; every stage holds its own valid bit.
// The depth is set by the dividers, which resolve one quotient bit a stage.
// Reset clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter
// Sextant RGB to HSV conversion: max/min, sextant numerator, constant
// multiply, then pipelined hue and saturation division.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [14:0] hue_deg_q6,
  output logic [12:0] sat_q12,
  output logic [7:0]  value_level,
  output logic        is_grey
);

  localparam int ChW  = hsv_pkg::CH_W;
  localparam int NumW = hsv_pkg::NUM_W;
  localparam int DvdW = hsv_pkg::DVD_W;

  // stage A: channels with max and min
  logic           va;
  logic [ChW-1:0] a_r, a_g, a_b, a_mx, a_mn;
  logic [ChW-1:0] in_mx, in_mn;

  // stage B: difference and sextant numerator
  logic            vb;
  logic [NumW-1:0] b_num;
  logic [ChW-1:0]  b_d, b_mx;
  logic            b_grey, b_black;

  // stage C: scaled hue and saturation dividends
  logic            vc;
  hsv_pkg::div_word_t c_word;

  logic rdy_a, rdy_b, rdy_c, rdy_o;
  logic div_in_ready, div_out_valid;
  hsv_pkg::div_stage_t div_out;

  logic [ChW-1:0]  d_a;
  logic [NumW-1:0] d_n, e_r, e_g, e_b, num_next;
  logic            r_max, g_max, b_max, r_min, g_min, b_min;

  always_comb begin
    in_mx = red;
    in_mn = red;
    if (green > in_mx) in_mx = green;
    if (blue > in_mx)  in_mx = blue;
    if (green < in_mn) in_mn = green;
    if (blue < in_mn)  in_mn = blue;
  end

  // sextant selection, ties go to the earlier test
  always_comb begin
    d_a   = a_mx - a_mn;
    d_n   = NumW'(d_a);
    e_r   = NumW'(a_mx - a_r);
    e_g   = NumW'(a_mx - a_g);
    e_b   = NumW'(a_mx - a_b);
    r_max = (a_r == a_mx);
    g_max = (a_g == a_mx);
    b_max = (a_b == a_mx);
    r_min = (a_r == a_mn);
    g_min = (a_g == a_mn);
    b_min = (a_b == a_mn);
    if (r_max && g_min) begin
      num_next = (d_n << 2) + d_n + e_b;
    end else if (r_max) begin
      num_next = d_n - e_g;
    end else if (g_max && b_min) begin
      num_next = d_n + e_r;
    end else if (g_max) begin
      num_next = (d_n << 1) + d_n - e_b;
    end else if (b_max && r_min) begin
      num_next = (d_n << 1) + d_n + e_g;
    end else begin
      num_next = (d_n << 2) + d_n - e_r;
    end
  end

  assign rdy_c    = !vc || div_in_ready;
  assign rdy_b    = !vb || rdy_c;
  assign rdy_a    = !va || rdy_b;
  assign in_stall = !rdy_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
    end else begin
      if (rdy_a) va <= in_valid;
      if (rdy_b) vb <= va;
      if (rdy_c) vc <= vb;
    end
    if (rdy_a) begin
      a_r  <= red;
      a_g  <= green;
      a_b  <= blue;
      a_mx <= in_mx;
      a_mn <= in_mn;
    end
    if (rdy_b) begin
      b_num   <= num_next;
      b_d     <= d_a;
      b_mx    <= a_mx;
      b_grey  <= (a_mx == a_mn);
      b_black <= (a_mx == '0);
    end
    if (rdy_c) begin
      c_word.hue_dvd <= DvdW'(b_num * hsv_pkg::HUE_SECTOR_Q6);
      c_word.hue_dvs <= b_d;
      c_word.sat_dvd <= DvdW'(b_d) << hsv_pkg::SAT_SHIFT;
      c_word.sat_dvs <= b_mx;
      c_word.value   <= b_mx;
      c_word.grey    <= b_grey;
      c_word.black   <= b_black;
    end
  end

  hsv_divpipe u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vc),
    .in_ready  (div_in_ready),
    .in_word   (c_word),
    .out_valid (div_out_valid),
    .out_ready (rdy_o),
    .out_word  (div_out)
  );

  // output register; grey forces hue to zero, black forces saturation to zero
  assign rdy_o = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy_o) begin
      out_valid <= div_out_valid;
    end
    if (rdy_o) begin
      hue_deg_q6  <= div_out.grey ? '0 : div_out.hue_quo[hsv_pkg::HUE_W-1:0];
      sat_q12     <= div_out.black ? '0 : div_out.sat_quo[hsv_pkg::SAT_W-1:0];
      value_level <= div_out.value;
      is_grey     <= div_out.grey;
    end
  end

endmodule

// ===== tb/rgb_to_hsv_converter_tb.sv =====
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_tb
// Drives RGB pixels into the converter: a directed set of corner pixels, then
// random pixels that are uniform, have tied channels, or are nearly grey.
// Each accepted word is predicted locally and checked against the results in
// order. Sender bursts and receiver stalls vary throughout the run.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter_tb;

  localparam int LATENCY_CYCLES = 19;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int MAX_REPORTS    = 10;

  typedef struct {
    logic [hsv_pkg::HUE_W-1:0] hue;
    logic [hsv_pkg::SAT_W-1:0] sat;
    logic [hsv_pkg::CH_W-1:0]  value;
    logic                      grey;
  } hsv_pixel_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_SPARSE,
    STALL_HEAVY,
    STALL_TOGGLE
  } stall_mode_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [hsv_pkg::CH_W-1:0]  red = '0;
  logic [hsv_pkg::CH_W-1:0]  green = '0;
  logic [hsv_pkg::CH_W-1:0]  blue = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [hsv_pkg::HUE_W-1:0] hue_deg_q6;
  logic [hsv_pkg::SAT_W-1:0] sat_q12;
  logic [hsv_pkg::CH_W-1:0]  value_level;
  logic                      is_grey;

  hsv_pixel_t  pixels_due[$];
  int          mismatches = 0;
  int          cycle_count = 0;
  int          burst_left = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_hold = 0;

  rgb_to_hsv_converter DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .hue_deg_q6  (hue_deg_q6),
    .sat_q12     (sat_q12),
    .value_level (value_level),
    .is_grey     (is_grey)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("rgb_to_hsv_converter: mismatch");
      $finish;
    end
  end

  // sextant hue, Q0.12 saturation, value = max channel
  function automatic hsv_pixel_t hsv_of_pixel(input logic [hsv_pkg::CH_W-1:0] r, g, b);
    hsv_pixel_t  res;
    int unsigned ri, gi, bi, mx, mn, d, num;
    ri = 32'(r);
    gi = 32'(g);
    bi = 32'(b);
    mx = ri;
    if (gi > mx) mx = gi;
    if (bi > mx) mx = bi;
    mn = ri;
    if (gi < mn) mn = gi;
    if (bi < mn) mn = bi;
    d = mx - mn;
    res.value = mx[hsv_pkg::CH_W-1:0];
    res.grey  = (d == 0);
    res.sat   = (mx == 0) ? '0 : hsv_pkg::SAT_W'((d << hsv_pkg::SAT_SHIFT) / mx);
    res.hue   = '0;
    if (d != 0) begin
      if (ri == mx && gi == mn)      num = 5 * d + (mx - bi);
      else if (ri == mx)             num = d - (mx - gi);
      else if (gi == mx && bi == mn) num = d + (mx - ri);
      else if (gi == mx)             num = 3 * d - (mx - bi);
      else if (bi == mx && ri == mn) num = 3 * d + (mx - gi);
      else                           num = 5 * d - (mx - ri);
      res.hue = hsv_pkg::HUE_W'((num * 32'(hsv_pkg::HUE_SECTOR_Q6)) / d);
    end
    return res;
  endfunction

  // receiver stall pattern: modes held for random stretches
  always @(posedge clk) begin
    if (stall_hold == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      stall_hold <= $urandom_range(40, 200);
    end else begin
      stall_hold <= stall_hold - 1;
    end
    case (stall_mode)
      STALL_NONE:   out_stall <= 1'b0;
      STALL_SPARSE: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY:  out_stall <= ($urandom_range(0, 3) != 0);
      STALL_TOGGLE: out_stall <= ~out_stall;
    endcase
  end

  // result checker
  always @(posedge clk) begin
    hsv_pixel_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pixels_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected word: hue=%0d sat=%0d value=%0d grey=%0d",
                   hue_deg_q6, sat_q12, value_level, is_grey);
      end else begin
        want = pixels_due.pop_front();
        if (hue_deg_q6 !== want.hue || sat_q12 !== want.sat ||
            value_level !== want.value || is_grey !== want.grey) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("bad word: hue %0d/%0d sat %0d/%0d value %0d/%0d grey %0d/%0d",
                     want.hue, hue_deg_q6, want.sat, sat_q12,
                     want.value, value_level, want.grey, is_grey);
        end
      end
    end
  end

  // one word; the sender may pause between bursts of random length
  task automatic send_pixel(input logic [hsv_pkg::CH_W-1:0] r, g, b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid <= 1'b1;
    red      <= r;
    green    <= g;
    blue     <= b;
    do @(posedge clk); while (in_stall);
    pixels_due.push_back(hsv_of_pixel(r, g, b));
  endtask

  task automatic test_directed();
    send_pixel(8'd0,   8'd0,   8'd0);     // black, also grey
    send_pixel(8'd255, 8'd255, 8'd255);   // white
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd255, 8'd0,   8'd0);     // pure red, 360 degrees
    send_pixel(8'd1,   8'd0,   8'd0);
    send_pixel(8'd255, 8'd254, 8'd254);
    send_pixel(8'd0,   8'd255, 8'd0);
    send_pixel(8'd0,   8'd0,   8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);     // yellow: red max, green not min
    send_pixel(8'd0,   8'd255, 8'd255);   // cyan
    send_pixel(8'd255, 8'd0,   8'd255);   // magenta: red wins the tie
    send_pixel(8'd255, 8'd0,   8'd1);     // just below 360
    send_pixel(8'd255, 8'd1,   8'd0);
    send_pixel(8'd1,   8'd255, 8'd0);
    send_pixel(8'd0,   8'd255, 8'd1);
    send_pixel(8'd0,   8'd1,   8'd255);
    send_pixel(8'd1,   8'd0,   8'd255);
    send_pixel(8'd254, 8'd255, 8'd255);
    send_pixel(8'd0,   8'd0,   8'd1);
    send_pixel(8'd0,   8'd1,   8'd0);
    send_pixel(8'hAA,  8'h55,  8'hAA);
    send_pixel(8'h55,  8'hAA,  8'h55);
    send_pixel(8'd1,   8'd1,   8'd1);
  endtask

  task automatic test_random_uniform(input int n);
    repeat (n)
      send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // two or three channels equal, to work the tie order of the sextants
  task automatic test_random_ties(input int n);
    logic [hsv_pkg::CH_W-1:0] p, q;
    repeat (n) begin
      p = 8'($urandom);
      q = ($urandom_range(0, 4) == 0) ? p : 8'($urandom);
      case ($urandom_range(0, 2))
        0: send_pixel(p, p, q);
        1: send_pixel(p, q, p);
        default: send_pixel(q, p, p);
      endcase
    end
  endtask

  // small spread between channels, so d is tiny and truncation bites
  task automatic test_random_near_grey(input int n);
    int base;
    int c[3];
    repeat (n) begin
      base = ($urandom_range(0, 3) == 0) ?
             (($urandom_range(0, 1) == 0) ? $urandom_range(0, 3) : $urandom_range(252, 255)) :
             $urandom_range(0, 255);
      foreach (c[i]) begin
        c[i] = base + $urandom_range(0, 6) - 3;
        if (c[i] < 0) c[i] = 0;
        if (c[i] > 255) c[i] = 255;
      end
      send_pixel(8'(c[0]), 8'(c[1]), 8'(c[2]));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_uniform(500);
    test_random_ties(350);
    test_random_near_grey(350);
    in_valid <= 1'b0;
    while (pixels_due.size() != 0) @(posedge clk);
    repeat (LATENCY_CYCLES + 5) @(posedge clk);
    if (mismatches == 0 && pixels_due.size() == 0)
      $display("rgb_to_hsv_converter: match");
    else
      $display("rgb_to_hsv_converter: mismatch");
    $finish;
  end

endmodule
